// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the packed list table engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define PLT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define PLT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/plt_pkg.sv =====
// Types and codes shared by the packed list table engine modules.
package plt_pkg;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_READ   = 2'd2,
        KIND_FIND   = 2'd3
    } plt_kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOTFOUND = 2'd3
    } plt_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RDWAIT,
        S_DONE
    } plt_state_t;

    typedef struct packed {
        plt_kind_t          req_type;
        logic signed [31:0] operand_value;
        logic [7:0]         operand_index;
    } plt_req_t;

    typedef struct packed {
        plt_status_t        status;
        logic signed [31:0] read_value;
        logic [7:0]         found_index;
        logic [8:0]         count_now;
    } plt_result_t;

endpackage

// ===== rtl/packed_list_table_engine_core.sv =====
// Top level of the packed list table engine: stream ports, result register, store and sequencer.
//
// Usage: a packed list of signed 32-bit words with a live count.
// Slave channel (s_): one request per transaction; s_tuser carries the request type
// (append, remove all equal, read at index, find first), s_tdata the operand value and index.
// Master channel (m_): one result per request; m_tuser carries the status, m_tdata the
// read value, the found index and the live count after the request.
// Append and an out-of-range read go straight to the done state; an in-range read passes
// S_RDWAIT for the registered store read; remove and find scan the list, reading one store
// entry per cycle through the single read port and, for remove, writing survivors back
// through the single write port. A find stops at its first match. Remove or find on an
// empty list skips the scan. The next request is taken once the previous result sits in
// the output register, so the sequencer works on one request at a time.
// Reset (aresetn low, synchronous) clears the live count and the control state; store
// contents are left as they are and never used before being written.
// When the receiver stalls, the result waits in the output register and one further
// request may be accepted and worked; its result then waits in the sequencer until the
// output register frees.
`include "assert_macros.svh"

module packed_list_table_engine_core #(
    parameter int DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    input  logic [39:0] s_tdata,   // [31:0] operand_value, [39:32] operand_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic [55:0] m_tdata    // [31:0] read_value, [39:32] found_index,
                                   // [48:40] count_now, [55:49] zero
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    plt_pkg::plt_req_t    req;
    plt_pkg::plt_result_t res;
    logic                 res_valid;
    logic                 res_ready;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [31:0]          mem_wdata;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [31:0]          mem_rdata;

    logic                 m_valid_reg, m_valid_next;
    plt_pkg::plt_result_t m_res_reg, m_res_next;

    // unpack the request transaction
    assign req.req_type      = plt_pkg::plt_kind_t'(s_tuser);
    assign req.operand_value = s_tdata[31:0];
    assign req.operand_index = s_tdata[39:32];

    plt_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    plt_seq #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // output register: load when empty or being drained this cycle
    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {7'd0, m_res_reg.count_now, m_res_reg.found_index, m_res_reg.read_value};

    // one request in the sequencer at a time
    `PLT_ASSERT_NEXT(a_single_request, s_tvalid && s_tready, !s_tready)
    // a finished result always lands in the output register
    `PLT_ASSERT_NEXT(a_result_lands, res_valid && res_ready, m_tvalid)
    // full is only reported with the store holding DEPTH words
    `PLT_ASSERT_SAME(a_full_count, m_tvalid && m_tuser == plt_pkg::ST_FULL,
                     m_tdata[48:40] == 9'(DEPTH))

endmodule

// ===== rtl/plt_store.sv =====
// Entry store: single write port, single read port, registered read data.
module plt_store #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [31:0]       wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [31:0]       rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/plt_seq.sv =====
// Request sequencer: append, compacting remove, indexed read and linear find over the store.
module plt_seq #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int CNT_W  = 9
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  plt_pkg::plt_req_t    req,
    output logic                 res_valid,
    input  logic                 res_ready,
    output plt_pkg::plt_result_t res,
    output logic                 mem_we,
    output logic [ADDR_W-1:0]    mem_waddr,
    output logic [31:0]          mem_wdata,
    output logic [ADDR_W-1:0]    mem_raddr,
    input  logic [31:0]          mem_rdata
);

    localparam int IW = CNT_W + 8;

    plt_pkg::plt_state_t  state_reg, state_next;
    plt_pkg::plt_kind_t   kind_reg, kind_next;
    logic [31:0]          val_reg, val_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0]    exam_reg, exam_next;
    plt_pkg::plt_status_t status_reg, status_next;
    logic [31:0]          rval_reg, rval_next;
    logic [7:0]           fidx_reg, fidx_next;

    logic                 accept;
    logic                 full;
    logic                 empty;
    logic                 idx_ok;
    logic                 match;
    logic                 last;
    logic [ADDR_W+7:0]    idx_ext;
    logic [ADDR_W+7:0]    exam_ext;
    logic [CNT_W+8:0]     cnt_ext;

    assign accept   = req_valid && req_ready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign idx_ok   = (IW'(req.operand_index) < IW'(count_reg));
    assign idx_ext  = (ADDR_W+8)'(req.operand_index);
    assign exam_ext = (ADDR_W+8)'(exam_reg);
    assign cnt_ext  = (CNT_W+9)'(count_reg);
    assign match    = (mem_rdata == val_reg);
    assign last     = ((CNT_W'(exam_reg) + CNT_W'(1)) == count_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            plt_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (req.req_type)
                        plt_pkg::KIND_APPEND: state_next = plt_pkg::S_DONE;
                        plt_pkg::KIND_READ:
                            state_next = idx_ok ? plt_pkg::S_RDWAIT : plt_pkg::S_DONE;
                        default:
                            state_next = empty ? plt_pkg::S_DONE : plt_pkg::S_SCAN;
                    endcase
                end
            end
            plt_pkg::S_SCAN: begin
                if (last || (kind_reg == plt_pkg::KIND_FIND && match)) begin
                    state_next = plt_pkg::S_DONE;
                end
            end
            plt_pkg::S_RDWAIT: state_next = plt_pkg::S_DONE;
            plt_pkg::S_DONE: begin
                if (res_ready) begin
                    state_next = plt_pkg::S_IDLE;
                end
            end
            default: state_next = plt_pkg::S_IDLE;
        endcase
    end

    // datapath and memory port
    always_comb begin
        kind_next   = kind_reg;
        val_next    = val_reg;
        count_next  = count_reg;
        wr_ptr_next = wr_ptr_reg;
        exam_next   = exam_reg;
        status_next = status_reg;
        rval_next   = rval_reg;
        fidx_next   = fidx_reg;
        mem_we      = 1'b0;
        mem_waddr   = count_reg[ADDR_W-1:0];
        mem_wdata   = req.operand_value;
        mem_raddr   = '0;
        req_ready   = (state_reg == plt_pkg::S_IDLE);
        res_valid   = (state_reg == plt_pkg::S_DONE);
        unique case (state_reg)
            plt_pkg::S_IDLE: begin
                mem_raddr = (req.req_type == plt_pkg::KIND_READ) ? idx_ext[ADDR_W-1:0] : '0;
                if (accept) begin
                    kind_next   = req.req_type;
                    val_next    = req.operand_value;
                    wr_ptr_next = '0;
                    exam_next   = '0;
                    status_next = plt_pkg::ST_OK;
                    rval_next   = '0;
                    fidx_next   = '0;
                    unique case (req.req_type)
                        plt_pkg::KIND_APPEND: begin
                            if (full) begin
                                status_next = plt_pkg::ST_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        plt_pkg::KIND_READ: begin
                            if (!idx_ok) begin
                                status_next = plt_pkg::ST_RANGE;
                            end
                        end
                        plt_pkg::KIND_FIND: begin
                            if (empty) begin
                                status_next = plt_pkg::ST_NOTFOUND;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            plt_pkg::S_SCAN: begin
                // writes land at or behind the entry under test; reads run ahead, no overlap
                mem_raddr = exam_reg + ADDR_W'(1);
                exam_next = exam_reg + ADDR_W'(1);
                mem_wdata = mem_rdata;
                mem_waddr = wr_ptr_reg[ADDR_W-1:0];
                if (kind_reg == plt_pkg::KIND_FIND) begin
                    if (match) begin
                        fidx_next = exam_ext[7:0];
                    end else if (last) begin
                        status_next = plt_pkg::ST_NOTFOUND;
                    end
                end else begin
                    if (!match) begin
                        mem_we      = 1'b1;
                        wr_ptr_next = wr_ptr_reg + CNT_W'(1);
                    end
                    if (last) begin
                        count_next = match ? wr_ptr_reg : wr_ptr_reg + CNT_W'(1);
                    end
                end
            end
            plt_pkg::S_RDWAIT: rval_next = mem_rdata;
            plt_pkg::S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= plt_pkg::S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        val_reg    <= val_next;
        wr_ptr_reg <= wr_ptr_next;
        exam_reg   <= exam_next;
        status_reg <= status_next;
        rval_reg   <= rval_next;
        fidx_reg   <= fidx_next;
    end

    assign res.status      = status_reg;
    assign res.read_value  = rval_reg;
    assign res.found_index = fidx_reg;
    assign res.count_now   = cnt_ext[8:0];

endmodule
